// ===== hw/rtl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average package
// Shared sizes, types and helper functions for the per-channel moving
// average block.
// ----------------------------------------------------------------------------
package mavg_pkg;

	localparam int CHANNELS   = 16;
	localparam int MAX_WINDOW = 64;

	localparam int CH_W      = 4;
	localparam int SMP_W     = 32;
	localparam int CFG_W     = 7;
	localparam int WIN_RESET = 8;

	localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
	localparam int POS_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH    = CHANNELS * MAX_WINDOW;
	localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W    = SMP_W + $clog2(MAX_WINDOW) + 1;
	localparam int CNT_W    = $clog2(SUM_W + 1);

	typedef struct packed {
		logic              wr;
		logic [IDX_W-1:0]  addr;
		logic [SMP_W-1:0]  data;
	} mavg_mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mavg_div_stat_t;

	// Zero acts as a window of one; values above the maximum are clamped.
	function automatic logic [WIN_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
		logic [31:0] v;
		v = 32'(cfg);
		if (v == 32'd0) begin
			return WIN_W'(1);
		end
		if (v > 32'(MAX_WINDOW)) begin
			return WIN_W'(MAX_WINDOW);
		end
		return WIN_W'(v);
	endfunction

endpackage

// ===== hw/rtl/per_channel_moving_average.sv =====
// ----------------------------------------------------------------------------
// Per-channel moving average
// Keeps a sliding window of signed Q16.16 samples for each channel and
// reports the window mean once the window is full.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_ready) carry a channel, a sample and a
// good flag. A transaction that is not good, or names a channel beyond the
// supported count, is dropped. A good sample is written into
// its channel's window and the running sum is updated; when the window is
// full, the mean is returned as an output transaction (out_valid/out_ready).
// An accepted good sample passes through the address, update and divide
// states before out_valid; the bit-serial divider produces one quotient bit
// per cycle over the 39-bit running sum. One sample is processed at a time,
// so a new sample is not accepted until the previous one is through.
// Writing cfg_wr_data with cfg_wr_en sets the window size and empties every
// window; it must only be done while the block is idle.
// Reset sets the window size to eight and empties every window; the sample
// memory is not cleared. A stalled receiver holds the result in the output
// register; the next sample is still accepted, and its own result waits
// until the output register is free.
// ----------------------------------------------------------------------------
module per_channel_moving_average
	import mavg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_W-1:0]         cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CH_W-1:0]          channel,
	input  logic signed [SMP_W-1:0]  sample,
	input  logic                     sample_good,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CH_W-1:0]          out_channel,
	output logic signed [SMP_W-1:0]  average
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADDR = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         cfg_q;
	logic [WIN_W-1:0]         fill_q [CHANNELS];
	logic [POS_W-1:0]         wpos_q [CHANNELS];
	logic signed [SUM_W-1:0]  sum_q  [CHANNELS];

	logic [CH_W-1:0]          ch_q;
	logic signed [SMP_W-1:0]  sample_q;
	logic [POS_W-1:0]         pos_q;
	logic                     full_q;
	logic [IDX_W-1:0]         slot_q;

	logic                     out_valid_q;
	logic [CH_W-1:0]          out_channel_q;
	logic [SMP_W-1:0]         average_q;

	logic [WIN_W-1:0]         win_eff;
	logic [CH_IDX_W-1:0]      ch_idx;
	logic [POS_W-1:0]         wpos_rd;
	logic [WIN_W-1:0]         fill_rd;
	logic signed [SUM_W-1:0]  sum_rd;
	logic [POS_W-1:0]         pos_c;
	logic [IDX_W-1:0]         slot_c;
	logic [WIN_W-1:0]         pos_inc;
	logic [POS_W-1:0]         wpos_next;
	logic [WIN_W-1:0]         fill_inc;
	logic [WIN_W-1:0]         fill_next;
	logic                     result_c;
	logic signed [SUM_W-1:0]  old_term;
	logic signed [SUM_W-1:0]  sum_next;
	logic                     in_take;
	logic                     out_free;
	logic                     out_load;

	mavg_mem_req_t            mem_req;
	logic signed [SMP_W-1:0]  mem_rd;
	mavg_div_stat_t           div_stat;
	logic                     div_start;
	logic [SMP_W-1:0]         div_quot;

	assign win_eff = eff_window(cfg_q);
	assign ch_idx  = CH_IDX_W'(ch_q);
	assign wpos_rd = wpos_q[ch_idx];
	assign fill_rd = fill_q[ch_idx];
	assign sum_rd  = sum_q[ch_idx];

	assign pos_c  = (WIN_W'(wpos_rd) >= win_eff) ? '0 : wpos_rd;
	assign slot_c = IDX_W'(32'(ch_idx) * MAX_WINDOW + 32'(pos_c));

	assign pos_inc   = WIN_W'(pos_q) + WIN_W'(1);
	assign wpos_next = (pos_inc >= win_eff) ? '0 : POS_W'(pos_inc);
	assign fill_inc  = fill_rd + WIN_W'(1);
	assign fill_next = full_q ? win_eff : fill_inc;
	assign result_c  = full_q || (fill_inc == win_eff);
	assign old_term  = full_q ? SUM_W'(mem_rd) : '0;
	assign sum_next  = sum_rd - old_term + SUM_W'(sample_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && sample_good && (32'(channel) < 32'(CHANNELS));
	assign out_free  = !out_valid_q || out_ready;
	assign out_load  = out_free && ((state_q == ST_DIV && div_stat.done) ||
		(state_q == ST_HOLD));
	assign div_start = (state_q == ST_UPD) && result_c;

	always_comb begin
		mem_req.wr   = 1'b0;
		mem_req.addr = slot_q;
		mem_req.data = sample_q;
		unique case (state_q)
			ST_ADDR: mem_req.addr = slot_c;
			ST_UPD:  mem_req.wr   = 1'b1;
			default: begin
			end
		endcase
	end

	mavg_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

	mavg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (win_eff),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_W'(WIN_RESET);
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				fill_q[i] <= '0;
				wpos_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
				for (int i = 0; i < CHANNELS; i++) begin
					fill_q[i] <= '0;
					wpos_q[i] <= '0;
					sum_q[i]  <= '0;
				end
			end else if (state_q == ST_UPD) begin
				fill_q[ch_idx] <= fill_next;
				wpos_q[ch_idx] <= wpos_next;
				sum_q[ch_idx]  <= sum_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= result_c ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_take) begin
			ch_q     <= channel;
			sample_q <= sample;
		end
		if (state_q == ST_ADDR) begin
			pos_q  <= pos_c;
			full_q <= (fill_rd >= win_eff);
			slot_q <= slot_c;
		end
		if (out_load) begin
			out_channel_q <= ch_q;
			average_q     <= div_quot;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign average     = signed'(average_q);

	// The state register always holds exactly one state.
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register is not one-hot");

	// A new transaction is never taken while a divide is in flight.
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> !div_stat.busy)
		else $error("input ready while the divider is busy");

	// The divider only finishes while the controller waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A window update is followed by either a divide or a return to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |=> (state_q == ST_DIV || state_q == ST_IDLE))
		else $error("unexpected state after window update");

endmodule

// ===== hw/rtl/mavg_store.sv =====
// ----------------------------------------------------------------------------
// Moving average sample store
// Single-port sample memory holding every channel's window, with a
// registered read port.
// ----------------------------------------------------------------------------
module mavg_store
	import mavg_pkg::*;
(
	input  logic                     clk,
	input  mavg_mem_req_t            req,
	output logic signed [SMP_W-1:0]  rd_data
);

	logic [SMP_W-1:0] mem [DEPTH];
	logic [SMP_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= req.data;
		end
		rd_q <= mem[req.addr];
	end

	assign rd_data = signed'(rd_q);

endmodule

// ===== hw/rtl/mavg_div.sv =====
// ----------------------------------------------------------------------------
// Moving average serial divider
// Bit-serial restoring divider of a signed running sum by the window size,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module mavg_div
	import mavg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [SUM_W-1:0]  dividend,
	input  logic [WIN_W-1:0]         divisor,
	output mavg_div_stat_t           stat,
	output logic [SMP_W-1:0]         quotient
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_ABS  = 4'b0010,
		D_STEP = 4'b0100,
		D_FIX  = 4'b1000
	} div_state_t;

	div_state_t        state_q;
	logic              done_q;
	logic              neg_q;
	logic [SUM_W-1:0]  mag_q;
	logic [WIN_W-1:0]  rem_q;
	logic [WIN_W-1:0]  div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SMP_W-1:0]  quot_q;

	logic [WIN_W:0]    trial;
	logic              fits;
	logic [WIN_W:0]    diff;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_ABS;
					end
				end
				D_ABS: begin
					cnt_q   <= CNT_W'(SUM_W - 1);
					state_q <= D_STEP;
				end
				D_STEP: begin
					if (cnt_q == '0) begin
						state_q <= D_FIX;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				D_FIX: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					mag_q <= dividend;
					neg_q <= dividend[SUM_W-1];
					div_q <= divisor;
				end
			end
			D_ABS: begin
				if (neg_q) begin
					mag_q <= '0 - mag_q;
				end
				rem_q <= '0;
			end
			D_STEP: begin
				rem_q <= fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
				mag_q <= {mag_q[SUM_W-2:0], fits};
			end
			D_FIX: begin
				quot_q <= neg_q ? SMP_W'('0 - mag_q) : mag_q[SMP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;
	assign quotient  = quot_q;

endmodule
